### rtl/core/cse_pkg.sv
package cse_pkg;

    // default table depth
    localparam int MAX_TERMS_DEF = 64;

    // fixed point format, Q3.28
    localparam int FRAC_BITS = 28;

    // tolerance register width and its reset value
    localparam int TOL_W = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

    // evaluation point limit, 1.1 in Q3.28
    localparam logic signed [31:0] POINT_LIMIT = 32'sd295279002;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRUNC = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
        logic [6:0]         term_count;
        logic signed [31:0] point;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic signed [31:0] series_value;
        logic [5:0]         kept_terms;
        logic               fault;
    } t_out_item;

endpackage

### rtl/core/chebyshev_series_evaluator_core.sv
// Chebyshev series evaluator. A coefficient write goes from idle through
// the done state back to idle, as does any request that ends in a fault
// before the loop starts. Evaluate runs the Clenshaw recurrence on one
// shared multiply-add unit, with a fetch state (table read and multiply)
// and then a step state (add and saturate) per term, then a final state.
// Truncate scans the table from slot term_count-1 downwards, with a fetch
// and a step state per slot visited, and stops at the first slot whose
// tail sum of magnitudes exceeds the tolerance. The request side stalls
// while a request is at work; a finished result waits in an output
// register, so the next request is taken while the result side stalls.
// The coefficient table is not cleared by reset: truncate or evaluate
// over a slot that was never written gives undefined values.
module chebyshev_series_evaluator_core #(
    parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cse_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cse_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cse_pkg::TOL_W-1:0]     i_cfg_data
);
    import cse_pkg::*;

    localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int IXW = (AW + 1 > 6) ? AW + 1 : 6;
    localparam int CW  = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int SW  = 32 + AW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_STEP  = 5'b00100,
        S_FIN   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [1:0]         r_op, n_op;
    logic [AW-1:0]      r_k, n_k;
    logic signed [30:0] r_twox, n_twox;
    logic signed [33:0] r_b0, n_b0, r_b1, n_b1, r_b2, n_b2;
    logic signed [64:0] r_prod, n_prod;
    logic [31:0]        r_rdata;
    logic [SW-1:0]      r_sum, n_sum;
    logic signed [31:0] r_value, n_value;
    logic [5:0]         r_kept, n_kept;
    logic               r_fault, n_fault;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [31:0]        r_coef [MAX_TERMS];

    logic               w_acc;
    logic [IXW-1:0]     w_idx_ext;
    logic               w_wr_en;
    logic [CW-1:0]      w_cnt_ext, w_cnt_m1;
    logic               w_cnt_bad, w_x_bad;
    logic signed [64:0] w_rnd;
    logic signed [36:0] w_q;
    logic [38:0]        w_s;
    logic               w_s_sat;
    logic signed [33:0] w_b_new;
    logic [31:0]        w_mag;
    logic [SW-1:0]      w_sum_n;
    logic [IXW-1:0]     w_k_ext;
    logic [35:0]        w_d;
    logic [34:0]        w_h;
    logic               w_h_sat;
    logic signed [31:0] w_res;

    // request decode
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_idx_ext   = IXW'(i_in_data.coef_index);
    assign w_wr_en     = w_acc && (i_in_data.operation == OP_WRITE)
                         && (w_idx_ext < IXW'(MAX_TERMS));
    assign w_cnt_ext   = CW'(i_in_data.term_count);
    assign w_cnt_m1    = w_cnt_ext - CW'(1);
    assign w_cnt_bad   = (w_cnt_ext == '0) || (w_cnt_ext > CW'(MAX_TERMS));
    assign w_x_bad     = (i_in_data.point < -POINT_LIMIT) || (i_in_data.point > POINT_LIMIT);

    // clenshaw step: rounded product, minus b1, plus coefficient, saturate to 34 bits
    assign w_rnd   = r_prod + 65'sd134217728;
    assign w_q     = w_rnd[64:FRAC_BITS];
    assign w_s     = {{2{w_q[36]}}, w_q} - {{5{r_b1[33]}}, r_b1}
                     + {{7{r_rdata[31]}}, r_rdata};
    assign w_s_sat = !((&w_s[38:33]) || !(|w_s[38:33]));
    assign w_b_new = !w_s_sat ? $signed(w_s[33:0]) :
                     (w_s[38] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}});

    // truncate step: magnitude and running tail sum
    assign w_mag   = r_rdata[31] ? (~r_rdata + 32'd1) : r_rdata;
    assign w_sum_n = r_sum + SW'(w_mag);
    assign w_k_ext = IXW'(r_k);

    // final half difference, saturate to 32 bits
    assign w_d     = {{2{r_b0[33]}}, r_b0} - {{2{r_b2[33]}}, r_b2} + 36'd1;
    assign w_h     = w_d[35:1];
    assign w_h_sat = !((&w_h[34:31]) || !(|w_h[34:31]));
    assign w_res   = !w_h_sat ? $signed(w_h[31:0]) :
                     (w_h[34] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_k         = r_k;
        n_twox      = r_twox;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_value     = r_value;
        n_kept      = r_kept;
        n_fault     = r_fault;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op    = i_in_data.operation;
                    n_k     = w_cnt_m1[AW-1:0];
                    n_twox  = {i_in_data.point[29:0], 1'b0};
                    n_b0    = '0;
                    n_b1    = '0;
                    n_b2    = '0;
                    n_sum   = '0;
                    n_value = '0;
                    n_kept  = '0;
                    n_fault = 1'b0;
                    n_state = S_DONE;
                    if (i_in_data.operation inside {OP_TRUNC, OP_EVAL}) begin
                        if (w_cnt_bad) begin
                            n_fault = 1'b1;
                        end else if (i_in_data.operation == OP_EVAL && w_x_bad) begin
                            n_fault = 1'b1;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_prod  = r_twox * r_b0;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_op == OP_TRUNC) begin
                    n_sum = w_sum_n;
                    if (w_sum_n > SW'(r_tol)) begin
                        n_kept  = w_k_ext[5:0];
                        n_state = S_DONE;
                    end else if (r_k == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k - AW'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_b2    = r_b1;
                    n_b1    = r_b0;
                    n_b0    = w_b_new;
                    n_fault = r_fault || w_s_sat;
                    if (r_k == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_k     = r_k - AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_FIN: begin
                n_value = w_res;
                n_fault = r_fault || w_h_sat;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.series_value = r_value;
                    n_out.kept_terms   = r_kept;
                    n_out.fault        = r_fault;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_k     <= n_k;
        r_twox  <= n_twox;
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_value <= n_value;
        r_kept  <= n_kept;
        r_fault <= n_fault;
        r_out   <= n_out;
    end

    // coefficient table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_coef[w_idx_ext[AW-1:0]] <= i_in_data.coef_value;
        end
        r_rdata <= r_coef[r_k];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted request always leaves idle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    // a new result is only loaded from the done state
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    // a nonzero slot comes only from a clean truncate
    a_kept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kept_terms != '0)
        |-> (o_out_data.series_value == '0 && !o_out_data.fault))
        else $error("slot reported together with value or fault");

    // the loop counter steps down by one on each pass back to fetch
    a_k_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && n_state == S_FETCH) |=> (r_k == $past(r_k) - AW'(1)))
        else $error("loop counter skipped");

endmodule
